[design/cpsf_pkg.sv]
// Shared constants, codes and types of the colinear path segment finder.
package cpsf_pkg;

    localparam int KIND_W     = 2;
    localparam int NODE_W     = 32;
    localparam int LEN_W      = 16;
    localparam int PATH_W     = 32;
    localparam int SEG_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 128;

    localparam int DEF_MAX_TARGET_NODES = 4096;
    localparam int DEF_OFFSET_BITS      = 32;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SOURCE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PATH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_PATH = 1'd1;

    typedef struct packed {
        logic [SEG_W-1:0] seg_end;
        logic [SEG_W-1:0] seg_start;
        logic             last;
    } seg_word_t;

endpackage

[design/cpsf_tmem.sv]
// Target node memory: one write port, one read port with registered read data.
module cpsf_tmem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 64
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/cpsf_outq.sv]
// Two-word result queue between the sequencer and the output channel.
module cpsf_outq
    import cpsf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  seg_word_t push_word,
    output logic      full,
    output logic      out_valid,
    input  logic      out_ready,
    output seg_word_t out_word
);

    seg_word_t   entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    assign full      = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_word  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

[design/cpsf_ctrl.sv]
// Sequencer: loads target entries, extends or closes runs, scans target memory.
module cpsf_ctrl
    import cpsf_pkg::*;
#(
    parameter int MAX_TARGET_NODES = DEF_MAX_TARGET_NODES,
    parameter int OFFSET_BITS      = DEF_OFFSET_BITS,
    parameter int IDX_W            = $clog2(MAX_TARGET_NODES),
    parameter int CNT_W            = $clog2(MAX_TARGET_NODES + 1),
    parameter int ENT_W            = NODE_W + OFFSET_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KIND_W-1:0] in_kind,
    input  logic [NODE_W-1:0] in_node,
    input  logic [LEN_W-1:0]  in_len,
    output logic              mem_we,
    output logic [IDX_W-1:0]  mem_waddr,
    output logic [ENT_W-1:0]  mem_wdata,
    output logic [IDX_W-1:0]  mem_raddr,
    input  logic [ENT_W-1:0]  mem_rdata,
    output logic              push,
    output seg_word_t         push_word,
    input  logic              q_full
);

    localparam int OFS_W = OFFSET_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXT  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [OFS_W-1:0]  total_reg, total_next;
    logic              tclosed_reg, tclosed_next;
    logic [OFS_W-1:0]  src_ofs_reg, src_ofs_next;
    logic              sclosed_reg, sclosed_next;
    logic              active_reg, active_next;
    logic [OFS_W-1:0]  rss_reg, rss_next;
    logic [OFS_W-1:0]  rts_reg, rts_next;
    logic [CNT_W-1:0]  rni_reg, rni_next;
    logic [OFS_W-1:0]  lte_reg, lte_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [OFS_W-1:0]  here_reg, here_next;
    logic [OFS_W-1:0]  here_end_reg, here_end_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              r1_valid_reg, r1_valid_next;
    seg_word_t         r1_reg, r1_next;
    logic              r2_valid_reg, r2_valid_next;
    seg_word_t         r2_reg, r2_next;

    logic [NODE_W-1:0] rd_node;
    logic [OFS_W-1:0]  rd_ofs;
    logic [CNT_W-1:0]  scan_inc;
    logic [CNT_W-1:0]  rni_inc;
    logic [OFS_W-1:0]  part_end;
    logic [OFS_W-1:0]  load_end;
    logic [OFS_W-1:0]  node_end;

    function automatic logic [OFS_W-1:0] sat_add(input logic [OFS_W-1:0] a,
                                                 input logic [OFS_W-1:0] b);
        logic [OFS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[OFS_W] ? '1 : s[OFS_W-1:0];
    endfunction

    function automatic logic [OFS_W-1:0] max_ofs(input logic [OFS_W-1:0] a,
                                                 input logic [OFS_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic seg_word_t make_seg(input logic [OFS_W-1:0] s,
                                           input logic [OFS_W-1:0] e);
        seg_word_t w;
        w.seg_start = SEG_W'(s);
        w.seg_end   = SEG_W'(e);
        w.last      = 1'b0;
        return w;
    endfunction

    assign rd_node  = mem_rdata[NODE_W-1:0];
    assign rd_ofs   = mem_rdata[ENT_W-1:NODE_W];
    assign scan_inc = scan_reg + CNT_W'(1);
    assign rni_inc  = rni_reg + CNT_W'(1);
    // source end of a run closed before the target end
    assign part_end = sat_add(rss_reg, rd_ofs - rts_reg);
    assign load_end = sat_add(total_reg, OFS_W'(in_len));
    assign node_end = sat_add(src_ofs_reg, OFS_W'(in_len));

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        tclosed_next  = tclosed_reg;
        src_ofs_next  = src_ofs_reg;
        sclosed_next  = sclosed_reg;
        active_next   = active_reg;
        rss_next      = rss_reg;
        rts_next      = rts_reg;
        rni_next      = rni_reg;
        lte_next      = lte_reg;
        node_next     = node_reg;
        here_next     = here_reg;
        here_end_next = here_end_reg;
        scan_next     = scan_reg;
        r1_valid_next = r1_valid_reg;
        r1_next       = r1_reg;
        r2_valid_next = r2_valid_reg;
        r2_next       = r2_reg;
        in_ready      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = count_reg[IDX_W-1:0];
        mem_wdata     = {total_reg, in_node};
        mem_raddr     = '0;
        push          = 1'b0;
        push_word     = r1_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                mem_raddr = active_reg ? rni_reg[IDX_W-1:0] : '0;
                if (in_valid)
                begin
                    case (in_kind)
                        KIND_LOAD:
                        begin
                            if (!tclosed_reg)
                            begin
                                if (in_node == '0)
                                begin
                                    tclosed_next = 1'b1;
                                end
                                else if (count_reg != CNT_W'(MAX_TARGET_NODES))
                                begin
                                    mem_we     = 1'b1;
                                    total_next = load_end;
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                        end
                        KIND_SOURCE:
                        begin
                            if (!sclosed_reg)
                            begin
                                if (in_node == '0)
                                begin
                                    sclosed_next = 1'b1;
                                end
                                else
                                begin
                                    here_next     = src_ofs_reg;
                                    here_end_next = node_end;
                                    src_ofs_next  = node_end;
                                    node_next     = in_node;
                                    scan_next     = '0;
                                    state_next    = active_reg ? ST_EXT : ST_SCAN;
                                end
                            end
                        end
                        KIND_FINISH:
                        begin
                            if (active_reg)
                            begin
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                count_next   = '0;
                                total_next   = '0;
                                tclosed_next = 1'b0;
                                src_ofs_next = '0;
                                sclosed_next = 1'b0;
                                rss_next     = '0;
                                rts_next     = '0;
                                rni_next     = '0;
                                lte_next     = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_EXT:
            begin
                // read data holds the expected target entry; issue entry 0 for a scan
                if (rd_node == node_reg)
                begin
                    rni_next   = rni_inc;
                    state_next = ST_IDLE;
                    if (rni_inc >= count_reg)
                    begin
                        active_next = 1'b0;
                        lte_next    = max_ofs(lte_reg, total_reg);
                        if (here_end_reg > rss_reg && total_reg > rts_reg)
                        begin
                            r2_valid_next = 1'b1;
                            r2_next       = make_seg(rss_reg, here_end_reg);
                            state_next    = ST_EMIT;
                        end
                    end
                end
                else
                begin
                    active_next = 1'b0;
                    lte_next    = max_ofs(lte_reg, rd_ofs);
                    if (part_end > rss_reg && rd_ofs > rts_reg)
                    begin
                        r1_valid_next = 1'b1;
                        r1_next       = make_seg(rss_reg, part_end);
                    end
                    scan_next  = '0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // read data holds entry scan_reg; next entry is issued now
                mem_raddr = scan_inc[IDX_W-1:0];
                if (scan_reg >= count_reg)
                begin
                    state_next = r1_valid_reg ? ST_EMIT : ST_IDLE;
                end
                else if (rd_node == node_reg && rd_ofs >= lte_reg)
                begin
                    rss_next    = here_reg;
                    rts_next    = rd_ofs;
                    rni_next    = scan_inc;
                    active_next = 1'b1;
                    state_next  = r1_valid_reg ? ST_EMIT : ST_IDLE;
                    if (scan_inc >= count_reg)
                    begin
                        active_next = 1'b0;
                        lte_next    = max_ofs(lte_reg, total_reg);
                        if (here_end_reg > here_reg && total_reg > rd_ofs)
                        begin
                            r2_valid_next = 1'b1;
                            r2_next       = make_seg(here_reg, here_end_reg);
                            state_next    = ST_EMIT;
                        end
                    end
                end
                else
                begin
                    scan_next = scan_inc;
                end
            end

            ST_FIN:
            begin
                state_next = ST_IDLE;
                if (part_end > rss_reg && rd_ofs > rts_reg)
                begin
                    r1_valid_next = 1'b1;
                    r1_next       = make_seg(rss_reg, part_end);
                    state_next    = ST_EMIT;
                end
                count_next   = '0;
                total_next   = '0;
                tclosed_next = 1'b0;
                src_ofs_next = '0;
                sclosed_next = 1'b0;
                active_next  = 1'b0;
                rss_next     = '0;
                rts_next     = '0;
                rni_next     = '0;
                lte_next     = '0;
            end

            ST_EMIT:
            begin
                if (r1_valid_reg)
                begin
                    push_word      = r1_reg;
                    push_word.last = !r2_valid_reg;
                    if (!q_full)
                    begin
                        push          = 1'b1;
                        r1_valid_next = 1'b0;
                        if (!r2_valid_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    push_word      = r2_reg;
                    push_word.last = 1'b1;
                    if (!q_full)
                    begin
                        push          = r2_valid_reg;
                        r2_valid_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            total_reg    <= '0;
            tclosed_reg  <= 1'b0;
            src_ofs_reg  <= '0;
            sclosed_reg  <= 1'b0;
            active_reg   <= 1'b0;
            rss_reg      <= '0;
            rts_reg      <= '0;
            rni_reg      <= '0;
            lte_reg      <= '0;
            scan_reg     <= '0;
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            tclosed_reg  <= tclosed_next;
            src_ofs_reg  <= src_ofs_next;
            sclosed_reg  <= sclosed_next;
            active_reg   <= active_next;
            rss_reg      <= rss_next;
            rts_reg      <= rts_next;
            rni_reg      <= rni_next;
            lte_reg      <= lte_next;
            scan_reg     <= scan_next;
            r1_valid_reg <= r1_valid_next;
            r2_valid_reg <= r2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        here_reg     <= here_next;
        here_end_reg <= here_end_next;
        r1_reg       <= r1_next;
        r2_reg       <= r2_next;
    end

endmodule

[design/colinear_path_segment_finder.sv]
// Colinear path segment finder: top level with configuration registers and checks.
//
// Input words arrive on s_tvalid/s_tready; s_tuser carries the kind (load target
// node, source node, finish), s_tdata the node handle and its base length.
// Target nodes are loaded first into the target memory with running offsets.
// Source nodes then extend the open run or close it and look for a new start.
// Result words leave on m_tvalid/m_tready as source base intervals, with the
// two path identifiers from the configuration port; m_tlast marks the final
// result of the input word that caused it.
// A target load, a closed or ignored word and a finish without an open run are
// handled in the idle step alone. A source node that extends the run also passes
// through the extend step. A node that must start a new run scans the target
// memory from entry 0, one entry per cycle through its one read port, until the
// node is found or the fill count is reached; an open run is closed first.
// A finish with an open run passes through the finish step.
// Each result is then pushed into the two-word output queue in the emit step.
// Reset clears all control state; the memory needs no clearing pass since only
// entries below the fill count are read. While the receiver stalls the queue
// fills and the sequencer holds in its push step with s_tready low.
module colinear_path_segment_finder
    import cpsf_pkg::*;
#(
    parameter int MAX_TARGET_NODES = DEF_MAX_TARGET_NODES,
    parameter int OFFSET_BITS      = DEF_OFFSET_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // node_id[31:0], node_length[47:32]
    input  logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // seg_source_path, seg_target_path,
                                             // seg_start, seg_end (32 bits each)
    output logic                  m_tlast,   // last_of_run
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [PATH_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(MAX_TARGET_NODES);
    localparam int CNT_W = $clog2(MAX_TARGET_NODES + 1);
    localparam int ENT_W = NODE_W + OFFSET_BITS;

    logic [PATH_W-1:0] src_id_reg;
    logic [PATH_W-1:0] tgt_id_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [ENT_W-1:0] mem_rdata;
    logic             push;
    seg_word_t        push_word;
    logic             q_full;
    seg_word_t        q_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_id_reg <= '0;
            tgt_id_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SOURCE_PATH: src_id_reg <= cfg_data;
                REG_TARGET_PATH: tgt_id_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    cpsf_ctrl #(
        .MAX_TARGET_NODES (MAX_TARGET_NODES),
        .OFFSET_BITS      (OFFSET_BITS),
        .IDX_W            (IDX_W),
        .CNT_W            (CNT_W),
        .ENT_W            (ENT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_node   (s_tdata[NODE_W-1:0]),
        .in_len    (s_tdata[NODE_W+LEN_W-1:NODE_W]),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .push      (push),
        .push_word (push_word),
        .q_full    (q_full)
    );

    cpsf_tmem #(
        .DEPTH  (MAX_TARGET_NODES),
        .ADDR_W (IDX_W),
        .DATA_W (ENT_W)
    ) u_tmem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    cpsf_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (q_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (q_word)
    );

    assign m_tdata = {q_word.seg_end, q_word.seg_start, tgt_id_reg, src_id_reg};
    assign m_tlast = q_word.last;

    // never push into a full result queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("result pushed into full queue");

    // a target load finishes in its own cycle
    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == KIND_LOAD) |=> s_tready)
        else $error("target load did not finish in one cycle");

    // an unused kind is dropped at once
    a_unused_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser != KIND_LOAD && s_tuser != KIND_SOURCE &&
         s_tuser != KIND_FINISH) |=> s_tready)
        else $error("unused kind was not dropped");

    // target memory is never written outside the idle step
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (s_tready && s_tvalid && s_tuser == KIND_LOAD))
        else $error("target memory written outside a load");

endmodule
